// ===== design/tsf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_pkg
// Types and constants shared by the turn signal flasher core and its step logic.
// ----------------------------------------------------------------------------
package tsf_pkg;

    localparam int PRESS_W = 16;
    localparam int BLINK_W = 17;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;

    localparam logic [PRESS_W-1:0] PRESS_MAX = '1;
    localparam logic [BLINK_W-1:0] BLINK_MAX = '1;

    localparam logic [CFG_W-1:0] HALF_PERIOD_RESET = 16'd500;
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET    = 16'd50;

    localparam logic [IDX_W-1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [IDX_W-1:0] REG_DEBOUNCE    = 2'd1;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_LEFT  = 2'd1,
        MODE_RIGHT = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic               lamp_phase;
        logic [BLINK_W-1:0] blink_elapsed;
        logic               left_previous;
        logic               right_previous;
        logic [PRESS_W-1:0] left_since_press;
        logic [PRESS_W-1:0] right_since_press;
    } flasher_state_t;

    typedef struct packed {
        logic  booster_on;
        logic  left_lamp;
        logic  right_lamp;
        mode_t mode;
    } flasher_result_t;

endpackage

// ===== design/turn_signal_flasher_core.sv =====
`timescale 1ns / 1ps
// A result is registered and is valid in the cycle after its item is accepted.
// Throughput: one item per cycle; the output register is refilled in the
// cycle it is taken, so input ready only drops while a result is held.
// Reset: mode off, lamp off, counters zero, switches released,
// half period 500 ms, debounce 50 ms, no result pending.
// ----------------------------------------------------------------------------
// turn_signal_flasher_core
// Turn signal flasher: one item per millisecond tick, debounced toggle of
// left/right indicator mode and blink timing with a registered result.
// ----------------------------------------------------------------------------
module turn_signal_flasher_core
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_write,
    input  logic [tsf_pkg::IDX_W-1:0]   cfg_index,
    input  logic [tsf_pkg::CFG_W-1:0]   cfg_data,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        left_switch,
    input  logic                        right_switch,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        booster_on,
    output logic                        left_lamp,
    output logic                        right_lamp,
    output logic [1:0]                  mode
);

    logic [tsf_pkg::CFG_W-1:0] half_period_reg;
    logic [tsf_pkg::CFG_W-1:0] debounce_reg;
    tsf_pkg::flasher_state_t   state_reg;
    tsf_pkg::flasher_state_t   state_next;
    tsf_pkg::flasher_result_t  result_reg;
    tsf_pkg::flasher_result_t  result_next;
    logic                      out_valid_reg;
    logic                      accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    tsf_step u_step
    (
        .state          (state_reg),
        .half_period_ms (half_period_reg),
        .debounce_ms    (debounce_reg),
        .left_switch    (left_switch),
        .right_switch   (right_switch),
        .state_next     (state_next),
        .result         (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= tsf_pkg::HALF_PERIOD_RESET;
            debounce_reg    <= tsf_pkg::DEBOUNCE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tsf_pkg::REG_HALF_PERIOD: half_period_reg <= cfg_data;
                tsf_pkg::REG_DEBOUNCE:    debounce_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode              <= tsf_pkg::MODE_OFF;
            state_reg.lamp_phase        <= 1'b0;
            state_reg.blink_elapsed     <= '0;
            state_reg.left_previous     <= 1'b1;
            state_reg.right_previous    <= 1'b1;
            state_reg.left_since_press  <= '0;
            state_reg.right_since_press <= '0;
            out_valid_reg               <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign booster_on = result_reg.booster_on;
    assign left_lamp  = result_reg.left_lamp;
    assign right_lamp = result_reg.right_lamp;
    assign mode       = result_reg.mode;

endmodule

// ===== design/tsf_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_step
// Next-state and result logic for one millisecond tick: left press, right
// press, then blink timing, then counter advance.
// ----------------------------------------------------------------------------
module tsf_step
(
    input  tsf_pkg::flasher_state_t            state,
    input  logic [tsf_pkg::CFG_W-1:0]          half_period_ms,
    input  logic [tsf_pkg::CFG_W-1:0]          debounce_ms,
    input  logic                               left_switch,
    input  logic                               right_switch,
    output tsf_pkg::flasher_state_t            state_next,
    output tsf_pkg::flasher_result_t           result
);

    logic                          left_fire;
    logic                          right_fire;
    tsf_pkg::mode_t                mode_l;
    tsf_pkg::mode_t                mode_r;
    logic                          phase_l;
    logic                          phase_r;
    logic                          phase_b;
    logic [tsf_pkg::BLINK_W-1:0]   elapsed_l;
    logic [tsf_pkg::BLINK_W-1:0]   elapsed_r;
    logic [tsf_pkg::BLINK_W-1:0]   elapsed_b;
    logic [tsf_pkg::BLINK_W-1:0]   full_period;
    logic [tsf_pkg::BLINK_W-1:0]   half_ext;

    assign full_period = {half_period_ms, 1'b0};
    assign half_ext    = {1'b0, half_period_ms};

    assign left_fire  = !left_switch && state.left_previous
                        && (state.left_since_press > debounce_ms);
    assign right_fire = !right_switch && state.right_previous
                        && (state.right_since_press > debounce_ms);

    always_comb
    begin
        // left switch
        mode_l    = state.mode;
        phase_l   = state.lamp_phase;
        elapsed_l = state.blink_elapsed;
        if (left_fire)
        begin
            mode_l    = (state.mode == tsf_pkg::MODE_LEFT) ? tsf_pkg::MODE_OFF
                                                           : tsf_pkg::MODE_LEFT;
            elapsed_l = '0;
            phase_l   = (mode_l != tsf_pkg::MODE_OFF);
        end

        // right switch, on the result of the left one
        mode_r    = mode_l;
        phase_r   = phase_l;
        elapsed_r = elapsed_l;
        if (right_fire)
        begin
            mode_r    = (mode_l == tsf_pkg::MODE_RIGHT) ? tsf_pkg::MODE_OFF
                                                        : tsf_pkg::MODE_RIGHT;
            elapsed_r = '0;
            phase_r   = (mode_r != tsf_pkg::MODE_OFF);
        end

        // blink
        phase_b   = phase_r;
        elapsed_b = elapsed_r;
        if (mode_r != tsf_pkg::MODE_OFF)
        begin
            if (elapsed_r >= half_ext)
            begin
                phase_b = 1'b0;
            end
            if (elapsed_r >= full_period)
            begin
                elapsed_b = '0;
                phase_b   = 1'b1;
            end
        end

        result.booster_on = phase_b;
        result.left_lamp  = phase_b && (mode_r == tsf_pkg::MODE_LEFT);
        result.right_lamp = phase_b && (mode_r == tsf_pkg::MODE_RIGHT);
        result.mode       = mode_r;

        state_next.mode           = mode_r;
        state_next.lamp_phase     = phase_b;
        state_next.left_previous  = left_switch;
        state_next.right_previous = right_switch;
        state_next.blink_elapsed  = (elapsed_b == tsf_pkg::BLINK_MAX)
                                    ? elapsed_b : elapsed_b + 1'b1;

        if (left_fire)
            state_next.left_since_press = tsf_pkg::PRESS_W'(1);
        else if (state.left_since_press == tsf_pkg::PRESS_MAX)
            state_next.left_since_press = state.left_since_press;
        else
            state_next.left_since_press = state.left_since_press + 1'b1;

        if (right_fire)
            state_next.right_since_press = tsf_pkg::PRESS_W'(1);
        else if (state.right_since_press == tsf_pkg::PRESS_MAX)
            state_next.right_since_press = state.right_since_press;
        else
            state_next.right_since_press = state.right_since_press + 1'b1;
    end

endmodule
